// ===== hw/rtl/turtle_grid_plotter_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Turtle grid plotter assertion macros
// Clocked assertion wrappers used by the plotter top level; compiled out with
// ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef TURTLE_GRID_PLOTTER_UNIT_MACROS_SVH
`define TURTLE_GRID_PLOTTER_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
// property holds at every edge out of reset
`define TGP_ASSERT(lbl, clk_s, rstn_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) prop) else $error(msg);
// expression is never true out of reset
`define TGP_ASSERT_NEVER(lbl, clk_s, rstn_s, expr, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) !(expr)) else $error(msg);
`else
`define TGP_ASSERT(lbl, clk_s, rstn_s, prop, msg)
`define TGP_ASSERT_NEVER(lbl, clk_s, rstn_s, expr, msg)
`endif
`endif

// ===== hw/rtl/tgp_pkg.sv =====
// ----------------------------------------------------------------------------
// Turtle grid plotter package
// Field widths, command codes, the decoded command beat and back-end types.
// ----------------------------------------------------------------------------
package tgp_pkg;

  // grid size defaults
  localparam int GRID_ROWS_DEF = 64;
  localparam int GRID_COLS_DEF = 64;

  // fixed port field widths
  localparam int MODE_W  = 3;
  localparam int FIELD_W = 6;

  // command queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // input mode codes
  localparam logic [MODE_W-1:0] MODE_PEN_UP   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_PEN_DOWN = 3'd1;
  localparam logic [MODE_W-1:0] MODE_TURN_R   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_TURN_L   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_MOVE     = 3'd4;
  localparam logic [MODE_W-1:0] MODE_READ     = 3'd5;

  // status codes
  localparam logic STATUS_DONE    = 1'b0;
  localparam logic STATUS_REFUSED = 1'b1;

  // decoded operation
  typedef enum logic [2:0] {
    OP_PEN_UP,
    OP_PEN_DOWN,
    OP_TURN_R,
    OP_TURN_L,
    OP_MOVE,
    OP_READ,
    OP_NOP
  } op_t;

  // heading, clockwise
  typedef enum logic [1:0] {
    HDG_EAST  = 2'd0,
    HDG_SOUTH = 2'd1,
    HDG_WEST  = 2'd2,
    HDG_NORTH = 2'd3
  } hdg_t;

  localparam logic [1:0] HDG_RIGHT_STEP = 2'd1;
  localparam logic [1:0] HDG_LEFT_STEP  = 2'd3;

  // one decoded command beat
  typedef struct packed {
    op_t                op;
    logic [FIELD_W-1:0] distance;
    logic [FIELD_W-1:0] query_row;
    logic [FIELD_W-1:0] query_col;
    logic               query_in_grid;
  } cmd_t;

  // back-end sequencer
  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_MOVE,
    BK_READ
  } bk_state_t;

  typedef struct packed {
    logic clearing;
    logic moving;
  } bk_stat_t;

endpackage

// ===== hw/rtl/tgp_front.sv =====
// ----------------------------------------------------------------------------
// Turtle grid plotter front end
// Takes command beats, decodes the mode and range-checks the query cell.
// ----------------------------------------------------------------------------
module tgp_front #(
  parameter int GRID_ROWS = tgp_pkg::GRID_ROWS_DEF,
  parameter int GRID_COLS = tgp_pkg::GRID_COLS_DEF
) (
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [tgp_pkg::MODE_W-1:0]   in_mode,
  input  logic [tgp_pkg::FIELD_W-1:0]  in_distance,
  input  logic [tgp_pkg::FIELD_W-1:0]  in_query_row,
  input  logic [tgp_pkg::FIELD_W-1:0]  in_query_col,
  output logic                         q_push,
  output tgp_pkg::cmd_t                q_data,
  input  logic                         q_full
);
  import tgp_pkg::*;

  op_t op;

  // mode decode; unused codes become no-ops
  always_comb begin
    case (in_mode)
      MODE_PEN_UP:   op = OP_PEN_UP;
      MODE_PEN_DOWN: op = OP_PEN_DOWN;
      MODE_TURN_R:   op = OP_TURN_R;
      MODE_TURN_L:   op = OP_TURN_L;
      MODE_MOVE:     op = OP_MOVE;
      MODE_READ:     op = OP_READ;
      default:       op = OP_NOP;
    endcase
  end

  // pack the beat for the queue
  always_comb begin
    q_data.op            = op;
    q_data.distance      = in_distance;
    q_data.query_row     = in_query_row;
    q_data.query_col     = in_query_col;
    q_data.query_in_grid = (32'(in_query_row) < 32'(GRID_ROWS)) &&
                           (32'(in_query_col) < 32'(GRID_COLS));
  end

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

endmodule

// ===== hw/rtl/tgp_queue.sv =====
// ----------------------------------------------------------------------------
// Turtle grid plotter command queue
// Short register FIFO decoupling the front end from the back end.
// ----------------------------------------------------------------------------
module tgp_queue (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        push,
  input  tgp_pkg::cmd_t               push_data,
  output logic                        full,
  input  logic                        pop,
  output tgp_pkg::cmd_t               pop_data,
  output logic                        empty,
  output logic [tgp_pkg::QCNT_W-1:0]  count
);
  import tgp_pkg::*;

  cmd_t              ent_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + QCNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_data;
    end
  end

  assign pop_data = ent_r[rd_ptr_r];
  assign empty    = (count_r == '0);
  assign full     = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign count    = count_r;

endmodule

// ===== hw/rtl/tgp_back.sv =====
// ----------------------------------------------------------------------------
// Turtle grid plotter back end
// Owns the turtle state and the bitmap, runs each command and drives results.
// ----------------------------------------------------------------------------
module tgp_back #(
  parameter int GRID_ROWS = tgp_pkg::GRID_ROWS_DEF,
  parameter int GRID_COLS = tgp_pkg::GRID_COLS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_empty,
  input  tgp_pkg::cmd_t                q_data,
  output logic                         q_pop,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_status,
  output logic                         out_cell_value,
  output logic [tgp_pkg::FIELD_W-1:0]  out_row_now,
  output logic [tgp_pkg::FIELD_W-1:0]  out_col_now,
  output logic [1:0]                   out_heading_now,
  output logic                         out_pen_now,
  output tgp_pkg::bk_stat_t            stat
);
  import tgp_pkg::*;

  localparam int RW    = $clog2(GRID_ROWS);
  localparam int CW    = $clog2(GRID_COLS);
  localparam int AW    = RW + CW;
  localparam int DEPTH = 1 << AW;

  // sequencer and turtle state
  bk_state_t           state_r, state_nxt;
  logic [RW-1:0]       row_r, row_nxt;
  logic [CW-1:0]       col_r, col_nxt;
  hdg_t                hdg_r, hdg_nxt;
  logic                pen_r, pen_nxt;
  logic [FIELD_W-1:0]  steps_r, steps_nxt;
  logic [AW-1:0]       clr_cnt_r, clr_cnt_nxt;
  logic                qin_r, qin_nxt;

  // bitmap
  logic                mem [DEPTH];
  logic                rd_data_r;
  logic                mem_we, mem_wdata, mem_re;
  logic [AW-1:0]       mem_waddr, mem_raddr;

  // result register
  logic                out_valid_r, out_valid_nxt;
  logic                out_status_r, out_cell_r, out_pen_r;
  logic [FIELD_W-1:0]  out_row_r, out_col_r;
  logic [1:0]          out_hdg_r;
  logic                out_load, res_status, res_cell;

  // helpers
  logic                slot_free, start, move_ok;
  logic [RW-1:0]       row_step;
  logic [CW-1:0]       col_step;
  logic [RW+FIELD_W-1:0] qrow_ext, row_ext;
  logic [CW+FIELD_W-1:0] qcol_ext, col_ext;

  assign slot_free = !out_valid_r || !out_stall;
  assign start     = (state_r == BK_IDLE) && !q_empty && slot_free;

  // bounds check on the current heading
  always_comb begin
    case (hdg_r)
      HDG_EAST:  move_ok = (32'(col_r) + 32'(q_data.distance)) < 32'(GRID_COLS);
      HDG_SOUTH: move_ok = (32'(row_r) + 32'(q_data.distance)) < 32'(GRID_ROWS);
      HDG_WEST:  move_ok = 32'(col_r) >= 32'(q_data.distance);
      HDG_NORTH: move_ok = 32'(row_r) >= 32'(q_data.distance);
      default:   move_ok = 1'b0;
    endcase
  end

  // one step along the heading
  always_comb begin
    row_step = row_r;
    col_step = col_r;
    case (hdg_r)
      HDG_EAST:  col_step = col_r + CW'(1);
      HDG_SOUTH: row_step = row_r + RW'(1);
      HDG_WEST:  col_step = col_r - CW'(1);
      HDG_NORTH: row_step = row_r - RW'(1);
      default:   row_step = row_r;
    endcase
  end

  // query cell address at grid width
  assign qrow_ext = {{RW{1'b0}}, q_data.query_row};
  assign qcol_ext = {{CW{1'b0}}, q_data.query_col};

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_CLEAR: begin
        if (clr_cnt_r == '1) begin
          state_nxt = BK_IDLE;
        end
      end
      BK_IDLE: begin
        if (start) begin
          case (q_data.op)
            OP_MOVE: begin
              if (move_ok && (q_data.distance != '0)) begin
                state_nxt = BK_MOVE;
              end
            end
            OP_READ: state_nxt = BK_READ;
            default: state_nxt = BK_IDLE;
          endcase
        end
      end
      BK_MOVE: begin
        if (steps_r == FIELD_W'(1)) begin
          state_nxt = BK_IDLE;
        end
      end
      BK_READ:  state_nxt = BK_IDLE;
      default:  state_nxt = BK_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    q_pop       = start;
    row_nxt     = row_r;
    col_nxt     = col_r;
    hdg_nxt     = hdg_r;
    pen_nxt     = pen_r;
    steps_nxt   = steps_r;
    clr_cnt_nxt = clr_cnt_r;
    qin_nxt     = qin_r;
    mem_we      = 1'b0;
    mem_waddr   = {row_step, col_step};
    mem_wdata   = pen_r;
    mem_re      = 1'b0;
    mem_raddr   = {qrow_ext[RW-1:0], qcol_ext[CW-1:0]};
    out_load    = 1'b0;
    res_status  = STATUS_DONE;
    res_cell    = 1'b0;
    case (state_r)
      BK_CLEAR: begin
        // sweep: every cell to zero, origin to one
        mem_we      = 1'b1;
        mem_waddr   = clr_cnt_r;
        mem_wdata   = (clr_cnt_r == '0);
        clr_cnt_nxt = clr_cnt_r + AW'(1);
      end
      BK_IDLE: begin
        if (start) begin
          case (q_data.op)
            OP_PEN_UP: begin
              pen_nxt  = 1'b0;
              out_load = 1'b1;
            end
            OP_PEN_DOWN: begin
              pen_nxt  = 1'b1;
              out_load = 1'b1;
            end
            OP_TURN_R: begin
              hdg_nxt  = hdg_t'(hdg_r + HDG_RIGHT_STEP);
              out_load = 1'b1;
            end
            OP_TURN_L: begin
              hdg_nxt  = hdg_t'(hdg_r + HDG_LEFT_STEP);
              out_load = 1'b1;
            end
            OP_MOVE: begin
              if (!move_ok) begin
                out_load   = 1'b1;
                res_status = STATUS_REFUSED;
              end else if (q_data.distance == '0) begin
                out_load = 1'b1;
              end else begin
                steps_nxt = q_data.distance;
              end
            end
            OP_READ: begin
              mem_re  = 1'b1;
              qin_nxt = q_data.query_in_grid;
            end
            default: begin
              out_load = 1'b1;
            end
          endcase
        end
      end
      BK_MOVE: begin
        // one cell per cycle, pen value into each cell entered
        row_nxt   = row_step;
        col_nxt   = col_step;
        mem_we    = 1'b1;
        steps_nxt = steps_r - FIELD_W'(1);
        if (steps_r == FIELD_W'(1)) begin
          out_load = 1'b1;
        end
      end
      BK_READ: begin
        out_load = 1'b1;
        res_cell = qin_r && rd_data_r;
      end
      default: begin
        out_load = 1'b0;
      end
    endcase
  end

  // result register handshake
  always_comb begin
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // reported position: low field bits of the new position
  assign row_ext = {{FIELD_W{1'b0}}, row_nxt};
  assign col_ext = {{FIELD_W{1'b0}}, col_nxt};

  // control and turtle registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_CLEAR;
      row_r       <= '0;
      col_r       <= '0;
      hdg_r       <= HDG_EAST;
      pen_r       <= 1'b0;
      steps_r     <= '0;
      clr_cnt_r   <= '0;
      qin_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      hdg_r       <= hdg_nxt;
      pen_r       <= pen_nxt;
      steps_r     <= steps_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      qin_r       <= qin_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status_r <= res_status;
      out_cell_r   <= res_cell;
      out_row_r    <= row_ext[FIELD_W-1:0];
      out_col_r    <= col_ext[FIELD_W-1:0];
      out_hdg_r    <= hdg_nxt;
      out_pen_r    <= pen_nxt;
    end
  end

  // bitmap: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= mem[mem_raddr];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_cell_value  = out_cell_r;
  assign out_row_now     = out_row_r;
  assign out_col_now     = out_col_r;
  assign out_heading_now = out_hdg_r;
  assign out_pen_now     = out_pen_r;

  assign stat.clearing = (state_r == BK_CLEAR);
  assign stat.moving   = (state_r == BK_MOVE);

endmodule

// ===== hw/rtl/turtle_grid_plotter_unit.sv =====
// ----------------------------------------------------------------------------
// Turtle grid plotter unit
// Command beats enter on the in_ channel (valid/stall); each gives exactly
// one result beat on the out_ channel with status, read value and the turtle
// row, column, heading and pen after the command.
// The front end decodes one beat per cycle into a two-entry command queue;
// in_stall rises only while that queue is full.
// The back end runs one command at a time. Pen and turn commands, refused
// moves and zero-length moves load their result directly; a cell read first
// goes through the registered bitmap read, and a move of n cells writes one
// cell per cycle through the single bitmap write port before its result.
// Reset puts the turtle at the origin facing east with the pen up, then a
// clearing pass over all 2^(clog2(GRID_ROWS) + clog2(GRID_COLS)) bitmap
// addresses zeroes the bitmap and sets the origin cell; commands queue up but
// none runs before it ends.
// While out_stall is high the result beat holds; the back end starts no new
// command until its result register is free, and the queue then fills.
// ----------------------------------------------------------------------------
`include "turtle_grid_plotter_unit_macros.svh"

module turtle_grid_plotter_unit #(
  parameter int GRID_ROWS = tgp_pkg::GRID_ROWS_DEF,
  parameter int GRID_COLS = tgp_pkg::GRID_COLS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [tgp_pkg::MODE_W-1:0]   in_mode,
  input  logic [tgp_pkg::FIELD_W-1:0]  in_distance,
  input  logic [tgp_pkg::FIELD_W-1:0]  in_query_row,
  input  logic [tgp_pkg::FIELD_W-1:0]  in_query_col,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_status,
  output logic                         out_cell_value,
  output logic [tgp_pkg::FIELD_W-1:0]  out_row_now,
  output logic [tgp_pkg::FIELD_W-1:0]  out_col_now,
  output logic [1:0]                   out_heading_now,
  output logic                         out_pen_now
);
  import tgp_pkg::*;

  logic              q_push, q_full, q_pop, q_empty;
  cmd_t              q_in, q_out;
  logic [QCNT_W-1:0] q_count;
  bk_stat_t          bk_stat;

  // decode
  tgp_front #(
    .GRID_ROWS (GRID_ROWS),
    .GRID_COLS (GRID_COLS)
  ) u_front (
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_mode      (in_mode),
    .in_distance  (in_distance),
    .in_query_row (in_query_row),
    .in_query_col (in_query_col),
    .q_push       (q_push),
    .q_data       (q_in),
    .q_full       (q_full)
  );

  // command queue
  tgp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_out),
    .empty     (q_empty),
    .count     (q_count)
  );

  // execute
  tgp_back #(
    .GRID_ROWS (GRID_ROWS),
    .GRID_COLS (GRID_COLS)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_empty         (q_empty),
    .q_data          (q_out),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_cell_value  (out_cell_value),
    .out_row_now     (out_row_now),
    .out_col_now     (out_col_now),
    .out_heading_now (out_heading_now),
    .out_pen_now     (out_pen_now),
    .stat            (bk_stat)
  );

  // checks
  `TGP_ASSERT(a_busy_no_result, clk, rst_n, (bk_stat.clearing || bk_stat.moving) |-> !out_valid, "result pending while back end clears or moves")
  `TGP_ASSERT_NEVER(a_refused_has_no_value, clk, rst_n, out_valid && out_status && out_cell_value, "refused move carries a cell value")
  `TGP_ASSERT(a_queue_bound, clk, rst_n, q_count <= QCNT_W'(QUEUE_DEPTH), "command queue over depth")

endmodule
